// ----- rtl/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger.
// Event and result item layouts, operation and register codes, and the
// fixed constants of the distance divide.
// ----------------------------------------------------------------------------
package uer_pkg;

	// Field widths fixed by the item layouts.
	localparam int TIME_BITS     = 16;
	localparam int PERIOD_BITS   = 16;
	localparam int DIST_BITS     = 11;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 1;

	// Event operation codes.
	typedef enum logic [1:0] {
		OP_EXPIRE  = 2'd0,
		OP_CAPTURE = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_HIGH_TICKS = 1'd0,
		REG_LOW_TICKS  = 1'd1
	} cfg_reg_t;

	localparam logic [PERIOD_BITS-1:0] HIGH_RESET = 16'd8;
	localparam logic [PERIOD_BITS-1:0] LOW_RESET  = 16'd37500;

	// Distance is echo ticks divided by 58, saturated to the field maximum.
	localparam int DIST_DIVISOR = 58;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	// Differences at or above this limit saturate; below it they fit SAT_BITS.
	localparam int SAT_LIMIT = DIST_DIVISOR * (2 ** DIST_BITS);
	localparam int SAT_BITS  = $clog2(SAT_LIMIT);
	// d / 58 = (d >> 1) / 29, and the halved value is divided by 29 through
	// a reciprocal that is exact for every HALF_BITS-bit value.
	localparam int HALF_BITS   = SAT_BITS - 1;
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP_BITS  = 17;
	localparam logic [RECIP_BITS-1:0] RECIP = 17'd72316;
	localparam int PROD_BITS   = HALF_BITS + RECIP_BITS;

	typedef struct packed {
		op_t                  operation;
		logic [TIME_BITS-1:0] capture_time;
		logic                 echo_level;
	} in_item_t;

	typedef struct packed {
		logic                   trigger_level;
		logic [PERIOD_BITS-1:0] next_period;
		logic [DIST_BITS-1:0]   distance;
		logic                   pulse_pending;
	} out_item_t;

endpackage

// ----- rtl/uer_in_if.sv -----
// ----------------------------------------------------------------------------
// uer_in_if: event channel of the echo ranger.
// Valid/ready handshake carrying one event item.
// ----------------------------------------------------------------------------
interface uer_in_if;
	import uer_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// ----- rtl/uer_out_if.sv -----
// ----------------------------------------------------------------------------
// uer_out_if: result channel of the echo ranger.
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface uer_out_if;
	import uer_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// ----- rtl/uer_dist.sv -----
// ----------------------------------------------------------------------------
// uer_dist: echo width to distance conversion.
// Wrapped stamp difference divided by 58 through a constant reciprocal.
// ----------------------------------------------------------------------------
module uer_dist #(
	parameter int STAMP_BITS = 16
) (
	input  logic [STAMP_BITS-1:0]         rise_stamp,
	input  logic [STAMP_BITS-1:0]         fall_stamp,
	output logic [uer_pkg::DIST_BITS-1:0] distance
);
	import uer_pkg::*;

	localparam int DW = (STAMP_BITS > SAT_BITS) ? STAMP_BITS : SAT_BITS;

	logic [STAMP_BITS-1:0] diff;
	logic [DW-1:0]         diff_w;
	logic                  sat;
	logic [HALF_BITS-1:0]  half;
	logic [PROD_BITS-1:0]  prod;

	// The subtraction wraps modulo 2^STAMP_BITS by construction.
	assign diff   = fall_stamp - rise_stamp;
	assign diff_w = DW'(diff);
	assign sat    = (diff_w >= DW'(SAT_LIMIT));
	assign half   = diff_w[SAT_BITS-1:1];
	assign prod   = PROD_BITS'(half) * PROD_BITS'(RECIP);

	assign distance = sat ? DIST_MAX : prod[RECIP_SHIFT +: DIST_BITS];

endmodule

// ----- rtl/ultrasonic_echo_ranger_core.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core: event-driven ultrasonic ranger controller.
// An event item is registered in the input stage on acceptance, and its result
// item is then registered in the result register. Throughput: one item per
// cycle unless the sink stalls; the update and the divide by 58 (a single
// 16x17 constant multiply) sit between the input and result registers.
// Reset: arst_n clears the trigger, the echo tracking, the stamps and the held
// distance, and returns both period registers to 8 and 37500 ticks.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core #(
	parameter int STAMP_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [uer_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	uer_in_if.sink                             in_ch,
	uer_out_if.source                          out_ch
);
	import uer_pkg::*;

	// Period registers; the user must write them only while the block is idle (not enforced here).
	logic [PERIOD_BITS-1:0] high_ticks_q;
	logic [PERIOD_BITS-1:0] low_ticks_q;

	// Controller state. It always reflects every item that has already left
	// the first stage, so the item in the first stage sees the right state.
	logic                  trigger_q;
	logic                  expect_rise_q;
	logic                  pending_q;
	logic [STAMP_BITS-1:0] rise_q;
	logic [STAMP_BITS-1:0] fall_q;
	logic [DIST_BITS-1:0]  held_q;

	// Input register stage.
	logic     valid_s1;
	in_item_t item_s1;

	// Result register, which also acts as the skid stage toward the sink.
	logic      out_valid_q;
	out_item_t out_item_q;

	logic out_free;
	logic advance;

	// Next-state values for the item in the first stage.
	logic                  trigger_d;
	logic                  expect_rise_d;
	logic                  pending_d;
	logic [STAMP_BITS-1:0] rise_d;
	logic [STAMP_BITS-1:0] fall_d;
	logic [DIST_BITS-1:0]  held_d;
	logic [STAMP_BITS-1:0] stamp_in;
	logic [DIST_BITS-1:0]  dist_new;
	logic [PERIOD_BITS-1:0] period_raw;
	out_item_t             result_d;

	// The result register can take a new item when it is empty or its item
	// is being taken in this cycle; the first stage may then move on, and the
	// input side may refill the first stage in the same cycle.
	assign out_free     = !out_valid_q || out_ch.ready;
	assign advance      = valid_s1 && out_free;
	assign in_ch.ready  = !valid_s1 || out_free;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_item_q;

	// Only the low STAMP_BITS bits of the capture time take part.
	assign stamp_in = STAMP_BITS'(item_s1.capture_time);

	uer_dist #(
		.STAMP_BITS(STAMP_BITS)
	) u_dist (
		.rise_stamp(rise_q),
		.fall_stamp(fall_q),
		.distance  (dist_new)
	);

	// Event decode: the new trigger, echo tracking and held distance.
	always_comb begin
		trigger_d     = trigger_q;
		expect_rise_d = expect_rise_q;
		pending_d     = pending_q;
		rise_d        = rise_q;
		fall_d        = fall_q;
		held_d        = held_q;
		unique case (item_s1.operation)
			OP_EXPIRE: begin
				trigger_d = !trigger_q;
			end
			OP_CAPTURE: begin
				if (expect_rise_q && item_s1.echo_level) begin
					rise_d        = stamp_in;
					pending_d     = 1'b1;
					expect_rise_d = 1'b0;
				end else if (!expect_rise_q && !item_s1.echo_level) begin
					fall_d        = stamp_in;
					pending_d     = 1'b0;
					expect_rise_d = 1'b1;
				end else begin
					// The echo level was not the one expected: start over and
					// wait for a fresh rising edge.
					rise_d        = '0;
					fall_d        = '0;
					pending_d     = 1'b0;
					expect_rise_d = 1'b1;
				end
			end
			OP_READ: begin
				// While a pulse is still open the last distance stands.
				if (!pending_q) begin
					held_d = dist_new;
				end
			end
			default: begin
				// The unused code leaves the state as it is.
			end
		endcase
	end

	// The reported period is the one matching the trigger level after the
	// event; a period register holding zero behaves as one tick.
	always_comb begin
		period_raw = trigger_d ? high_ticks_q : low_ticks_q;
		result_d.trigger_level = trigger_d;
		result_d.next_period   = (period_raw == '0) ? PERIOD_BITS'(1) : period_raw;
		result_d.distance      = held_d;
		result_d.pulse_pending = pending_d;
	end

	// Configuration writes. Indexes beyond the list do not exist here, since
	// the index is exactly as wide as the register list needs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_ticks_q <= HIGH_RESET;
			low_ticks_q  <= LOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HIGH_TICKS: high_ticks_q <= cfg_data;
				REG_LOW_TICKS:  low_ticks_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Controller state commits as the item moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q     <= 1'b0;
			expect_rise_q <= 1'b1;
			pending_q     <= 1'b0;
			rise_q        <= '0;
			fall_q        <= '0;
			held_q        <= '0;
		end else if (advance) begin
			trigger_q     <= trigger_d;
			expect_rise_q <= expect_rise_d;
			pending_q     <= pending_d;
			rise_q        <= rise_d;
			fall_q        <= fall_d;
			held_q        <= held_d;
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.payload;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result_d;
		end
	end

endmodule

// ----- dv/echo_ranger_checker.sv -----
// ----------------------------------------------------------------------------
// echo_ranger_checker: result predictor and comparator of the echo ranger.
// Watches both item channels and the period register port, keeps its own copy
// of the ranger state, and checks every result item against its prediction.
// ----------------------------------------------------------------------------
module echo_ranger_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [uer_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	uer_in_if                                  ev_mon,
	uer_out_if                                 res_mon,
	output int                                 mismatches,
	output int                                 backlog,
	output int                                 results_seen
);
	import uer_pkg::*;

	logic [PERIOD_BITS-1:0] high_ticks;
	logic [PERIOD_BITS-1:0] low_ticks;
	logic                   trig_q;
	logic                   await_rise;
	logic                   echo_open;
	logic [TIME_BITS-1:0]   rise_t;
	logic [TIME_BITS-1:0]   fall_t;
	logic [DIST_BITS-1:0]   dist_hold;
	out_item_t              awaited_results[$];

	// Applies one event to the ranger state and returns the result it reports.
	function automatic out_item_t apply_event(in_item_t ev);
		logic [TIME_BITS-1:0]   span;
		int unsigned            quotient;
		logic [PERIOD_BITS-1:0] period;
		out_item_t              res;
		case (ev.operation)
			OP_EXPIRE: begin
				trig_q = ~trig_q;
			end
			OP_CAPTURE: begin
				if (await_rise && ev.echo_level) begin
					rise_t = ev.capture_time;
					echo_open = 1'b1;
					await_rise = 1'b0;
				end else if (!await_rise && !ev.echo_level) begin
					fall_t = ev.capture_time;
					echo_open = 1'b0;
					await_rise = 1'b1;
				end else begin
					// Level out of step with the tracking: start over.
					rise_t = '0;
					fall_t = '0;
					await_rise = 1'b1;
					echo_open = 1'b0;
				end
			end
			OP_READ: begin
				if (!echo_open) begin
					span = fall_t - rise_t;
					quotient = span / DIST_DIVISOR;
					dist_hold = (quotient > DIST_MAX) ? DIST_MAX : DIST_BITS'(quotient);
				end
			end
			default: begin
			end
		endcase
		period = trig_q ? high_ticks : low_ticks;
		if (period == '0) begin
			period = PERIOD_BITS'(1);
		end
		res.trigger_level = trig_q;
		res.next_period = period;
		res.distance = dist_hold;
		res.pulse_pending = echo_open;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			high_ticks = HIGH_RESET;
			low_ticks = LOW_RESET;
			trig_q = 1'b0;
			await_rise = 1'b1;
			echo_open = 1'b0;
			rise_t = '0;
			fall_t = '0;
			dist_hold = '0;
			awaited_results.delete();
			mismatches = 0;
			backlog = 0;
			results_seen = 0;
		end else begin
			// Results first, so a result never meets the item entering at the same edge.
			if (res_mon.valid && res_mon.ready) begin
				got = res_mon.payload;
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result item with no event waiting: %p", got);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got.trigger_level !== want.trigger_level) begin
						$error("trigger_level: expected %0d, actual %0d",
							want.trigger_level, got.trigger_level);
						mismatches++;
					end
					if (got.next_period !== want.next_period) begin
						$error("next_period: expected %0d, actual %0d",
							want.next_period, got.next_period);
						mismatches++;
					end
					if (got.distance !== want.distance) begin
						$error("distance: expected %0d, actual %0d",
							want.distance, got.distance);
						mismatches++;
					end
					if (got.pulse_pending !== want.pulse_pending) begin
						$error("pulse_pending: expected %0d, actual %0d",
							want.pulse_pending, got.pulse_pending);
						mismatches++;
					end
				end
			end
			if (ev_mon.valid && ev_mon.ready) begin
				awaited_results.push_back(apply_event(ev_mon.payload));
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_HIGH_TICKS: high_ticks = cfg_data;
					REG_LOW_TICKS:  low_ticks = cfg_data;
					default: begin
					end
				endcase
			end
			backlog = awaited_results.size();
		end
	end

endmodule

// ----- dv/tb_ultrasonic_echo_ranger_core.sv -----
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_core: self-checking bench of the echo ranger core.
// Drives trigger expiries, echo captures and distance reads through the event
// channel under several period settings, with random idling on both channels,
// and lets echo_ranger_checker predict and compare every result item.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_core;
	import uer_pkg::*;

	// Cycles without any accepted item before the run is declared hung. The
	// longest legal quiet stretch is the deliberate result-side hold.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RX_HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS    = 165;
	localparam int PHASE_COUNT    = 5;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	uer_in_if  ev_if ();
	uer_out_if res_if ();

	int mismatches;
	int backlog;
	int results_seen;
	int items_sent     = 0;
	int idle_cycles    = 0;
	int settings_used  = 1;
	bit quiet_mode     = 1'b0;
	bit rx_hold_req    = 1'b0;

	ultrasonic_echo_ranger_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (ev_if),
		.out_ch    (res_if)
	);

	echo_ranger_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ev_mon       (ev_if),
		.res_mon      (res_if),
		.mismatches   (mismatches),
		.backlog      (backlog),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	// Offers one event item and returns at the falling edge after it was taken.
	// The caller must drive valid at that edge, either for the next item or low.
	// Now and then the sender goes quiet for a short burst before returning.
	task automatic offer_event(op_t op, logic [TIME_BITS-1:0] stamp, logic level);
		ev_if.valid <= 1'b1;
		ev_if.payload <= '{operation: op, capture_time: stamp, echo_level: level};
		do @(posedge clk); while (!ev_if.ready);
		items_sent++;
		@(negedge clk);
		if (!quiet_mode && $urandom_range(0, 5) == 0) begin
			ev_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	// Stops offering items and waits until every predicted result has arrived.
	// Every event yields exactly one result, so an empty backlog means idle.
	task automatic await_drain();
		ev_if.valid <= 1'b0;
		while (backlog != 0) @(negedge clk);
	endtask

	// Writes both period registers on back-to-back cycles; only called while idle.
	task automatic set_periods(logic [CFG_DATA_BITS-1:0] high_val,
			logic [CFG_DATA_BITS-1:0] low_val);
		cfg_we <= 1'b1;
		cfg_index <= REG_HIGH_TICKS;
		cfg_data <= high_val;
		@(negedge clk);
		cfg_index <= REG_LOW_TICKS;
		cfg_data <= low_val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic. Most of it is complete ranging cycles (trigger pulse, echo
	// rise, echo fall, distance read) with random stamps and echo widths, so the
	// distance path is exercised with real values. The rest is single random
	// items and broken captures that force the echo tracking to resynchronize.
	task automatic random_traffic(int count);
		int                   stop_at;
		int                   kind;
		logic [TIME_BITS-1:0] t0;
		logic [TIME_BITS-1:0] width;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				t0 = TIME_BITS'($urandom);
				// Mostly short echoes, sometimes any width including wrapped ones.
				width = ($urandom_range(0, 3) == 0) ? TIME_BITS'($urandom)
					: TIME_BITS'($urandom_range(0, 3000));
				offer_event(OP_EXPIRE, TIME_BITS'($urandom), 1'($urandom));
				offer_event(OP_CAPTURE, t0, 1'b1);
				if ($urandom_range(0, 1) == 1) begin
					offer_event(OP_READ, TIME_BITS'($urandom), 1'($urandom));
				end
				offer_event(OP_EXPIRE, TIME_BITS'($urandom), 1'($urandom));
				offer_event(OP_CAPTURE, t0 + width, 1'b0);
				offer_event(OP_READ, TIME_BITS'($urandom), 1'($urandom));
			end else if (kind < 9) begin
				offer_event(op_t'($urandom_range(0, 3)), TIME_BITS'($urandom), 1'($urandom));
			end else begin
				offer_event(OP_CAPTURE, TIME_BITS'($urandom), 1'b1);
				offer_event(OP_CAPTURE, TIME_BITS'($urandom), 1'b1);
				offer_event(OP_READ, TIME_BITS'($urandom), 1'($urandom));
			end
		end
	endtask

	// Result-side ready. It idles in short random bursts, and once on request
	// holds off for a long stretch so the core fills up and stalls its input.
	// In the last part of the run it stays ready.
	initial begin
		res_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				res_if.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
				res_if.ready <= 1'b1;
			end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a run that stops moving items is a failure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", idle_cycles);
				$display("tb_ultrasonic_echo_ranger_core: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ev_if.valid = 1'b0;
		ev_if.payload = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, under the reset periods first. A read straight after
		// reset computes from two zero stamps.
		offer_event(OP_READ, 16'hffff, 1'b1);
		// Two expiries: the trigger rises (high period) and falls (low period).
		offer_event(OP_EXPIRE, 16'h0000, 1'b0);
		offer_event(OP_EXPIRE, 16'hffff, 1'b1);
		// Echo rise at stamp zero; a read while the pulse is open keeps the
		// held distance. The fall at the largest stamp gives the largest distance.
		offer_event(OP_CAPTURE, 16'h0000, 1'b1);
		offer_event(OP_READ, 16'h0000, 1'b0);
		offer_event(OP_CAPTURE, 16'hffff, 1'b0);
		offer_event(OP_READ, 16'h5555, 1'b0);
		// A low level while a rise is awaited clears both stamps.
		offer_event(OP_CAPTURE, 16'h1234, 1'b0);
		offer_event(OP_READ, 16'haaaa, 1'b1);
		// A high level while a fall is awaited also resynchronizes.
		offer_event(OP_CAPTURE, 16'hffc6, 1'b1);
		offer_event(OP_CAPTURE, 16'h0000, 1'b1);
		// An echo that wraps past the top of the stamp range: 58 ticks, distance 1.
		offer_event(OP_CAPTURE, 16'hffc6, 1'b1);
		offer_event(OP_CAPTURE, 16'h0000, 1'b0);
		// The unused operation code changes nothing and never recomputes.
		offer_event(OP_NONE, 16'hffff, 1'b1);
		offer_event(OP_READ, 16'hffff, 1'b1);
		offer_event(OP_NONE, 16'h0000, 1'b0);

		// A zero high period acts as one tick; the low period at its maximum.
		await_drain();
		set_periods(16'd0, 16'hffff);
		settings_used++;
		offer_event(OP_EXPIRE, 16'h0f0f, 1'b0);
		offer_event(OP_EXPIRE, 16'hf0f0, 1'b1);
		// And the other way round, with a zero low period.
		await_drain();
		set_periods(16'hffff, 16'd0);
		settings_used++;
		offer_event(OP_EXPIRE, 16'h00ff, 1'b1);
		offer_event(OP_EXPIRE, 16'hff00, 1'b0);
		offer_event(OP_CAPTURE, 16'h8000, 1'b1);

		// Random phases, each under its own period setting. The sender drains
		// the core before every register write. The hold-off on the result side
		// happens once while the sender keeps offering, and the last phase
		// runs with no idling at all.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			await_drain();
			case (ph)
				0: set_periods(HIGH_RESET, LOW_RESET);
				1: set_periods(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
				2: set_periods(16'd1, 16'hffff);
				3: begin
					set_periods(16'hffff, 16'd1);
					rx_hold_req = 1'b1;
				end
				default: begin
					set_periods(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
					quiet_mode = 1'b1;
				end
			endcase
			settings_used++;
			random_traffic(PHASE_ITEMS);
		end

		// Let the last results come out, then a few cycles more for anything stray.
		await_drain();
		repeat (6) @(negedge clk);

		$display("Run covered %0d events and %0d checked results under %0d period settings,",
			items_sent, results_seen, settings_used);
		$display("including zero and maximum periods, wrapped echoes and a long result stall.");
		if (mismatches == 0 && backlog == 0) begin
			$display("tb_ultrasonic_echo_ranger_core: clean");
		end else begin
			$display("tb_ultrasonic_echo_ranger_core: errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/uer_pkg.sv
rtl/uer_in_if.sv
rtl/uer_out_if.sv
rtl/uer_dist.sv
rtl/ultrasonic_echo_ranger_core.sv
dv/echo_ranger_checker.sv
dv/tb_ultrasonic_echo_ranger_core.sv
